@@ rtl/cts_pkg.sv @@
// Shared types, constants and keyword tables for the calculator token scanner.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cts_pkg;

	// Identifier length limit and the width of the length counter
	localparam int MAX_LEN = 128;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam logic [7:0] MAX_LEN_B = 8'(MAX_LEN % 256);

	// Result queue geometry
	localparam int Q_DEPTH = 4;
	localparam int QP_W = $clog2(Q_DEPTH);
	localparam int QC_W = $clog2(Q_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_W = 8'h77;

	typedef enum logic [3:0] {
		TK_READ      = 4'd0,
		TK_WRITE     = 4'd1,
		TK_ID        = 4'd2,
		TK_LITERAL   = 4'd3,
		TK_GETS      = 4'd4,
		TK_LPAREN    = 4'd5,
		TK_RPAREN    = 4'd6,
		TK_ADD       = 4'd7,
		TK_SUB       = 4'd8,
		TK_MUL       = 4'd9,
		TK_DIV       = 4'd10,
		TK_EOF       = 4'd11,
		TK_BAD_CHAR  = 4'd12,
		TK_BAD_COLON = 4'd13,
		TK_TOO_LONG  = 4'd14
	} token_kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_IDENT  = 5'b00010,
		MODE_NUMBER = 5'b00100,
		MODE_COLON  = 5'b01000,
		MODE_HALT   = 5'b10000
	} scan_mode_t;

	// Character class flags from the classifier
	typedef struct packed {
		logic        letter;
		logic        digit;
		logic        space;
		logic        under;
		logic        equal;
		logic        colon;
		logic        op_hit;
		token_kind_t op_kind;
	} char_class_t;

	// One result item
	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  len;
		logic        last;
	} token_t;

	// Results caused by one character: count 0..2, first goes out first
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} token_pair_t;

	// Letters of "read"
	function automatic logic [7:0] kw_read_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h72;
			2'd1: c = 8'h65;
			2'd2: c = 8'h61;
			default: c = 8'h64;
		endcase
		return c;
	endfunction

	// Letters of "write"; positions past the end are never compared
	function automatic logic [7:0] kw_write_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd1: c = 8'h72;
			3'd2: c = 8'h69;
			3'd3: c = 8'h74;
			3'd4: c = 8'h65;
			default: c = 8'h77;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/cts_classify.sv @@
// Character classifier: letter, digit, whitespace and punctuation decode.
// Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_classify (
	input  logic [7:0]          ch,
	output cts_pkg::char_class_t cls
);
	import cts_pkg::*;

	// Decode the byte into class flags
	always_comb begin
		cls.letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
		cls.digit = (ch >= 8'h30) && (ch <= 8'h39);
		cls.space = (ch == CH_SPACE) || ((ch >= 8'h09) && (ch <= 8'h0D));
		cls.under = (ch == CH_UNDER);
		cls.equal = (ch == CH_EQUAL);
		cls.colon = (ch == CH_COLON);
		cls.op_hit = 1'b1;
		unique case (ch)
			CH_LPAREN: cls.op_kind = TK_LPAREN;
			CH_RPAREN: cls.op_kind = TK_RPAREN;
			CH_PLUS:   cls.op_kind = TK_ADD;
			CH_MINUS:  cls.op_kind = TK_SUB;
			CH_STAR:   cls.op_kind = TK_MUL;
			CH_SLASH:  cls.op_kind = TK_DIV;
			default: begin
				cls.op_hit = 1'b0;
				cls.op_kind = TK_BAD_CHAR;
			end
		endcase
	end

endmodule

@@ rtl/cts_step.sv @@
// Scanner state (mode, length, keyword prefix flags) and the per-character
// token decision. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           ch,
	input  logic                 eoi,
	input  cts_pkg::char_class_t cls,
	output cts_pkg::token_pair_t res
);
	import cts_pkg::*;

	scan_mode_t       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             rd_q, rd_d, wr_q, wr_d;

	// Start-of-token decode
	logic             st_emit;
	token_kind_t      st_kind;
	logic [7:0]       st_len8;
	scan_mode_t       st_mode;
	logic [LEN_W-1:0] st_len;
	logic             st_rd, st_wr;

	logic             rd_upd, wr_upd, cont_id, cont_num;
	token_kind_t      id_kind;

	// Keyword prefix tracking for the next identifier character
	always_comb begin
		rd_upd = rd_q && (len_q < LEN_W'(4)) && (kw_read_char(len_q[1:0]) == ch);
		wr_upd = wr_q && (len_q < LEN_W'(5)) && (kw_write_char(len_q[2:0]) == ch);
		cont_id = !eoi && (cls.letter || cls.digit || cls.under);
		cont_num = !eoi && cls.digit;
		if (rd_q && (len_q == LEN_W'(4))) begin
			id_kind = TK_READ;
		end else if (wr_q && (len_q == LEN_W'(5))) begin
			id_kind = TK_WRITE;
		end else begin
			id_kind = TK_ID;
		end
	end

	// Scan the character as the first one of a new token
	always_comb begin
		st_emit = 1'b0;
		st_kind = TK_EOF;
		st_len8 = 8'd0;
		st_mode = MODE_IDLE;
		st_len = '0;
		st_rd = rd_q;
		st_wr = wr_q;
		if (eoi) begin
			st_emit = 1'b1;
			st_mode = MODE_HALT;
		end else if (cls.space) begin
			st_mode = MODE_IDLE;
		end else if (cls.letter) begin
			st_mode = MODE_IDENT;
			st_len = LEN_W'(1);
			st_rd = (ch == CH_R);
			st_wr = (ch == CH_W);
		end else if (cls.digit) begin
			st_mode = MODE_NUMBER;
			st_len = LEN_W'(1);
		end else if (cls.colon) begin
			st_mode = MODE_COLON;
			st_len = LEN_W'(1);
		end else if (cls.op_hit) begin
			st_emit = 1'b1;
			st_kind = cls.op_kind;
			st_len8 = 8'd1;
		end else begin
			st_emit = 1'b1;
			st_kind = TK_BAD_CHAR;
			st_len8 = 8'd1;
			st_mode = MODE_HALT;
		end
	end

	// Per-mode token decision
	always_comb begin
		mode_d = mode_q;
		len_d = len_q;
		rd_d = rd_q;
		wr_d = wr_q;
		res.count = 2'd0;
		res.first = '{kind: st_kind, len: st_len8, last: 1'b0};
		res.second = '{kind: st_kind, len: st_len8, last: 1'b0};
		unique case (mode_q)
			MODE_IDLE: begin
				res.count = {1'b0, st_emit};
				mode_d = st_mode;
				len_d = st_len;
				rd_d = st_rd;
				wr_d = st_wr;
			end
			MODE_IDENT: begin
				if (cont_id) begin
					if (len_q >= LEN_W'(MAX_LEN)) begin
						res.count = 2'd1;
						res.first.kind = TK_TOO_LONG;
						res.first.len = MAX_LEN_B;
						mode_d = MODE_HALT;
					end else begin
						rd_d = rd_upd;
						wr_d = wr_upd;
						len_d = len_q + LEN_W'(1);
					end
				end else begin
					res.count = st_emit ? 2'd2 : 2'd1;
					res.first.kind = id_kind;
					res.first.len = 8'(len_q);
					mode_d = st_mode;
					len_d = st_len;
					rd_d = st_rd;
					wr_d = st_wr;
				end
			end
			MODE_NUMBER: begin
				if (cont_num) begin
					if (len_q < LEN_W'(MAX_LEN)) begin
						len_d = len_q + LEN_W'(1);
					end
				end else begin
					res.count = st_emit ? 2'd2 : 2'd1;
					res.first.kind = TK_LITERAL;
					res.first.len = 8'(len_q);
					mode_d = st_mode;
					len_d = st_len;
					rd_d = st_rd;
					wr_d = st_wr;
				end
			end
			MODE_COLON: begin
				res.count = 2'd1;
				len_d = '0;
				if (!eoi && cls.equal) begin
					res.first.kind = TK_GETS;
					res.first.len = 8'd2;
					mode_d = MODE_IDLE;
				end else begin
					res.first.kind = TK_BAD_COLON;
					res.first.len = 8'd1;
					mode_d = MODE_HALT;
				end
			end
			MODE_HALT: begin
				mode_d = MODE_HALT;
			end
			default: begin
				mode_d = MODE_HALT;
			end
		endcase
		// Mark the final result of this character
		res.first.last = (res.count == 2'd1);
		res.second.last = 1'b1;
	end

	// Advance state on each consumed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q <= '0;
			rd_q <= 1'b1;
			wr_q <= 1'b1;
		end else if (fire) begin
			mode_q <= mode_d;
			len_q <= len_d;
			rd_q <= rd_d;
			wr_q <= wr_d;
		end
	end

`ifndef ASSERT_OFF
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_HALT) |=> (mode_q == MODE_HALT))
		else $error("scanner left the halted mode");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("token length counter above limit");
	a_idle_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (len_q == '0))
		else $error("length counter not cleared in idle mode");
`endif

endmodule

@@ rtl/cts_outq.sv @@
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cts_pkg::token_pair_t pair,
	output logic                 room2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cts_pkg::token_t      out_tok
);
	import cts_pkg::*;

	token_t          mem_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0] cnt_q;
	logic [1:0]      push_n;
	logic            pop;

	assign push_n = push ? pair.count : 2'd0;
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_tok = mem_q[rd_ptr_q];
	assign room2 = (cnt_q <= QC_W'(Q_DEPTH - 2));

	// Store pushed tokens in order
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= pair.first;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + QP_W'(1)] <= pair.second;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QP_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			cnt_q <= cnt_q + QC_W'(push_n) - QC_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q + QC_W'(push_n) <= QC_W'(Q_DEPTH) + QC_W'(pop)))
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(Q_DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

@@ rtl/calculator_token_scanner.sv @@
// Top level of the calculator token scanner: input register, classifier,
// scanner step and result queue. Depends on cts_pkg, cts_classify, cts_step, cts_outq.
`timescale 1ns / 1ps

// The scanner takes one character per cycle on the slave stream and
// emits tokens on the master stream, one per cycle while m_tready is
// high. A character passes an input register, then the scan logic and
// the result queue, before its tokens reach the master stream. Most
// characters give zero or one token; a character that closes an
// identifier or a number and is itself a one-character token (operator,
// parenthesis, bad character, end mark) gives two, and because the output
// side drains one token per cycle such characters cost the output side
// an extra token. Input is held off only while the four-entry result
// queue has fewer than two free entries. After the end token or any error
// token the scanner drops all further input until reset.
module calculator_token_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tuser,   // [0] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_length
	output logic [3:0] m_tuser,   // [3:0] token_kind
	output logic       m_tlast
);
	import cts_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        eoi_s1;
	logic        consume;
	logic        room2;
	char_class_t cls;
	token_pair_t pair;
	token_t      out_tok;

	assign consume = valid_s1 && room2;
	assign s_tready = !valid_s1 || consume;

	// Hold the accepted transaction until the scan logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
			eoi_s1 <= s_tuser;
		end
	end

	cts_classify u_classify (
		.ch  (ch_s1),
		.cls (cls)
	);

	cts_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (consume),
		.ch     (ch_s1),
		.eoi    (eoi_s1),
		.cls    (cls),
		.res    (pair)
	);

	cts_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (consume),
		.pair      (pair),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok)
	);

	// Drive the result transaction
	assign m_tdata = out_tok.len;
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last;

endmodule
